FILE: rtl/swmp_pkg.sv
package swmp_pkg;

  localparam int MAX_WINDOW_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // window_len register
  localparam int WINLEN_W     = 11;
  localparam int WINLEN_RESET = 64;

endpackage

FILE: rtl/swmp_ring.sv
module swmp_ring #(
  parameter int DEPTH  = swmp_pkg::MAX_WINDOW_DEF,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 31
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);
  import swmp_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/swmp_div.sv
// Restoring divider, one quotient bit per cycle. The caller guarantees
// dividend < divisor * 2^Q_W, so the quotient fits Q_W bits.
module swmp_div #(
  parameter int SUM_W = 41,
  parameter int Q_W   = 31,
  parameter int LEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);
  import swmp_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   num_r, num_nxt;
  logic [LEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[Q_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(Q_W);
      rem_nxt  = LEN_W'(dividend >> Q_W);
      num_nxt  = dividend[Q_W-1:0];
    end else if (busy_r) begin
      // numerator bits shift out the top, quotient bits shift in at the bottom
      rem_nxt = fits ? LEN_W'(trial - {1'b0, divisor}) : LEN_W'(trial);
      num_nxt = {num_r[Q_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

FILE: rtl/sliding_window_mean_power.sv
// Sliding-window mean power.
// in_*  : one signed sample per item (in_tdata[SAMPLE_BITS-1:0], upper pad bits ignored).
// out_* : mean of the squares over the last L samples (out_tdata[2*SAMPLE_BITS-2:0],
//         unsigned, pad bits zero), one item per input once L samples are held.
// cfg_* : cfg_wen writes window_len from cfg_wdata; L is window_len clamped to
//         1..MAX_WINDOW. A write empties the window. Write only while idle.
// Timing: an accepted sample is squared on entry, the ring slot is read and
//   rewritten in the next cycle together with the running sum, then the sum is
//   divided by L in a bit-serial divider. A result appears on out_tvalid in
//   the same cycle in which the next sample can be taken. The divider sets the rate.
// Reset (rst_n low, synchronous): window emptied, window_len back to 64 (at most
//   MAX_WINDOW), no output pending. Ring contents are not cleared; a slot's old
//   value is used only after the slot has been written.
// Stall: a result waiting on out_tready stays in the output register; the
//   next sample can still enter, but its result waits in the divider until
//   the output register frees up.
module sliding_window_mean_power #(
  parameter int MAX_WINDOW  = swmp_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swmp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]           in_tdata,   // sample
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((2*SAMPLE_BITS-1+7)/8)*8-1:0]       out_tdata,  // power
  input  logic                                       cfg_wen,
  input  logic [swmp_pkg::WINLEN_W-1:0]              cfg_wdata
);
  import swmp_pkg::*;

  localparam int POWER_W = 2 * SAMPLE_BITS - 1;
  localparam int OUT_W   = ((POWER_W + 7) / 8) * 8;
  localparam int ADDR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = POWER_W + $clog2(MAX_WINDOW);
  localparam logic [LEN_W-1:0] LEN_RST =
    (WINLEN_RESET > MAX_WINDOW) ? LEN_W'(MAX_WINDOW) : LEN_W'(WINLEN_RESET);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt, cfg_len;
  logic [LEN_W-1:0]   fill_r, fill_nxt, fill_inc;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [POWER_W-1:0] sq_r, sq_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [POWER_W-1:0] out_data_r, out_data_nxt;

  logic                          in_acc;
  logic                          upd;
  logic                          out_load;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic [POWER_W-1:0]            old_sq;
  logic                          div_start;
  logic                          div_done;
  logic [POWER_W-1:0]            div_q;
  logic [LEN_W-1:0]              idx_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign upd       = (state_r == S_UPD);

  assign smp    = in_tdata[SAMPLE_BITS-1:0];
  assign prod   = smp * smp;
  assign sq_nxt = prod[POWER_W-1:0];

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_len = LEN_W'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
      cfg_len = LEN_W'(MAX_WINDOW);
    end else begin
      cfg_len = LEN_W'(cfg_wdata);
    end
  end

  assign fill_inc = fill_r + 1'b1;
  assign idx_inc  = LEN_W'(idx_r) + 1'b1;
  assign out_load = div_done && (state_r == S_DIV) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    div_start   = 1'b0;
    out_vld_nxt = out_vld_r;
    out_data_nxt = out_data_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // drop the oldest square only once the window is full
        sum_nxt = sum_r - ((fill_r == len_r) ? SUM_W'(old_sq) : '0) + SUM_W'(sq_r);
        idx_nxt = (idx_inc >= len_r) ? '0 : ADDR_W'(idx_inc);
        if (fill_r != len_r) begin
          fill_nxt = fill_inc;
        end
        if ((fill_r == len_r) || (fill_inc == len_r)) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (out_load) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = div_q;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wen) begin
      len_nxt  = cfg_len;
      fill_nxt = '0;
      idx_nxt  = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      len_r     <= LEN_RST;
      fill_r    <= '0;
      idx_r     <= '0;
      sum_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_r <= sq_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  swmp_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (ADDR_W),
    .DATA_W (POWER_W)
  ) u_ring (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (idx_r),
    .rd_data (old_sq),
    .wr_en   (upd),
    .wr_addr (idx_r),
    .wr_data (sq_r)
  );

  swmp_div #(
    .SUM_W (SUM_W),
    .Q_W   (POWER_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

FILE: rtl/swmp_chk.sv
module swmp_chk #(
  parameter int SAMPLE_BITS = swmp_pkg::SAMPLE_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*SAMPLE_BITS-1+7)/8)*8-1:0] out_tdata
);
  import swmp_pkg::*;

  localparam int OUT_W = ((2 * SAMPLE_BITS - 1 + 7) / 8) * 8;
  localparam logic [OUT_W-1:0] PWR_MAX = OUT_W'(1) << (2 * SAMPLE_BITS - 2);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  // mean square never exceeds full scale squared; pad bits stay zero
  a_pwr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= PWR_MAX)
    else $error("power out of range");

  // one sample in flight: no acceptance in the cycle after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous item in flight");

  // a new result never appears right after an acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too early after input");

endmodule

bind sliding_window_mean_power swmp_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swmp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
